// ===== rtl/crc16fc_pkg.sv =====
// ============================================================================
// crc16fc_pkg
// Constants, status codes and the CRC-16/MODBUS byte update for the frame
// checker.
// ============================================================================
package crc16fc_pkg;

    localparam int BUFFER_BYTES = 64;
    localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
    localparam int LEN_CMP_W    = 9;    // wide enough for L + 4 and the count

    localparam logic [7:0]  HDR_BYTE       = 8'hF5;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam int          MIN_FRAME      = 5;
    localparam int          FRAME_OVERHEAD = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(BUFFER_BYTES);

    // byte positions inside the frame
    localparam logic [CNT_W-1:0] POS_HDR    = CNT_W'(0);
    localparam logic [CNT_W-1:0] POS_CRC_HI = CNT_W'(1);
    localparam logic [CNT_W-1:0] POS_CRC_LO = CNT_W'(2);
    localparam logic [CNT_W-1:0] POS_LEN    = CNT_W'(3);

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_HDR  = 3'd1;
    localparam logic [2:0] ST_SHORT    = 3'd2;
    localparam logic [2:0] ST_LEN_MISM = 3'd3;
    localparam logic [2:0] ST_CRC_MISM = 3'd4;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_IDLE = 1'b1;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// ===== rtl/crc16_frame_checker_unit.sv =====
// ============================================================================
// crc16_frame_checker_unit
// Checks framed bytes against header, length and CRC-16/MODBUS on line idle.
// ============================================================================
// Usage:
//   Slave stream s_axis carries one beat per received byte (s_axis_tuser = 0,
//   byte in s_axis_tdata[7:0]) or a line-idle beat (s_axis_tuser = 1) that
//   closes the frame. Frame layout: 0xF5, CRC high, CRC low, length L, then
//   L payload bytes; the CRC covers the payload only.
//   Master stream m_axis carries one result beat per idle beat: ok flag,
//   status code and the byte count (saturated at the buffer size).
//   Bytes past the buffer size are dropped and left out of the CRC.
// Timing:
//   One beat per cycle is accepted while s_axis_tready is high. A beat is
//   captured in the input register and processed from there, payload bytes
//   by the byte-wide CRC; m_axis_tvalid rises once an idle result is registered.
// Reset:
//   Synchronous, active low; clears the valid flags of both stages and the frame state.
// Stalls:
//   Byte beats never wait on m_axis. An idle beat waits in the input register
//   while a result is still pending on a stalled m_axis, and s_axis_tready
//   drops only then.
// ============================================================================
module crc16_frame_checker_unit
    import crc16fc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [0] frame_ok, [3:1] frame_status,
                                        // [10:4] frame_bytes, [15:11] zero
);

    // input register
    logic       r_in_valid;
    logic       r_in_op;
    logic [7:0] r_in_byte;

    // frame state
    logic [CNT_W-1:0] r_count,    n_count;
    logic             r_hdr_seen, n_hdr_seen;
    logic [15:0]      r_exp_crc,  n_exp_crc;
    logic [7:0]       r_decl_len, n_decl_len;
    logic [15:0]      r_crc,      n_crc;

    // result register
    logic       r_out_valid;
    logic       r_out_ok;
    logic [2:0] r_out_status;
    logic [6:0] r_out_bytes;

    logic                 out_free;
    logic                 advance;
    logic                 in_take;
    logic [2:0]           status;
    logic [LEN_CMP_W-1:0] len_total;
    logic [LEN_CMP_W-1:0] cnt_ext;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && (r_in_op == OP_BYTE || out_free);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign len_total = LEN_CMP_W'(r_decl_len) + LEN_CMP_W'(FRAME_OVERHEAD);
    assign cnt_ext   = LEN_CMP_W'(r_count);

    always_comb begin
        if (!r_hdr_seen) begin
            status = ST_BAD_HDR;
        end else if (cnt_ext < LEN_CMP_W'(MIN_FRAME)) begin
            status = ST_SHORT;
        end else if (cnt_ext != len_total) begin
            status = ST_LEN_MISM;
        end else if (r_exp_crc != r_crc) begin
            status = ST_CRC_MISM;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        n_count    = r_count;
        n_hdr_seen = r_hdr_seen;
        n_exp_crc  = r_exp_crc;
        n_decl_len = r_decl_len;
        n_crc      = r_crc;
        if (advance) begin
            if (r_in_op == OP_IDLE) begin
                // close the frame and start over
                n_count    = '0;
                n_hdr_seen = 1'b0;
                n_exp_crc  = '0;
                n_decl_len = '0;
                n_crc      = CRC_INIT;
            end else if (r_count < CNT_MAX) begin
                case (r_count)
                    POS_HDR:    n_hdr_seen = (r_in_byte == HDR_BYTE);
                    POS_CRC_HI: n_exp_crc  = {r_in_byte, r_exp_crc[7:0]};
                    POS_CRC_LO: n_exp_crc  = {r_exp_crc[15:8], r_in_byte};
                    POS_LEN:    n_decl_len = r_in_byte;
                    default:    n_crc      = crc16_byte(r_crc, r_in_byte);
                endcase
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_hdr_seen  <= 1'b0;
            r_exp_crc   <= '0;
            r_decl_len  <= '0;
            r_crc       <= CRC_INIT;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance && r_in_op == OP_IDLE) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            r_count    <= n_count;
            r_hdr_seen <= n_hdr_seen;
            r_exp_crc  <= n_exp_crc;
            r_decl_len <= n_decl_len;
            r_crc      <= n_crc;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op   <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
        if (advance && r_in_op == OP_IDLE) begin
            r_out_ok     <= (status == ST_OK);
            r_out_status <= status;
            r_out_bytes  <= r_count[6:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_bytes, r_out_status, r_out_ok};

`ifndef SYNTHESIS
    a_cnt_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("byte count above buffer size");

    a_ok_matches_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_ok == (r_out_status == ST_OK)))
        else $error("ok flag disagrees with status");

    a_idle_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_op == OP_IDLE) |=> (r_count == '0 && r_crc == CRC_INIT))
        else $error("frame state not cleared after idle");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out_status)
            && $stable(r_out_bytes)))
        else $error("pending result overwritten");
`endif

endmodule
